FILE: rtl/chi_pkg.sv
`timescale 1ns / 1ps
package chi_pkg;

  // Operation kinds carried in tuser
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_BUCKET_BITS = 1'b0;
  localparam logic CFG_INDEX_LIMIT = 1'b1;

  localparam logic [3:0]  BUCKET_BITS_RST = 4'd10;
  localparam logic [12:0] INDEX_LIMIT_RST = 13'd4096;

  // Widths fixed by the stream fields
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 12;
  localparam int MASK_W   = 15;  // bucket_bits tops out at 15
  localparam int IN_DW    = 48;
  localparam int OUT_DW   = 8;
  localparam int CFG_DW   = 13;

  // Controller -> datapath
  typedef struct packed {
    logic       acc;          // latch input transaction
    logic       clr_wr;       // write empty marker at sweep address
    logic       q_ld;         // load reciprocal quotient
    logic       b_ld;         // load bucket number
    logic       link_at_cur;  // link RAM read address: walk pointer
    logic       add_wr;       // push index at bucket head
    logic       rmh_wr;       // head takes next link of index
    logic       walk_init;    // start walk from head
    logic       walk_step;    // advance walk pointer
    logic       rml_wr;       // bypass index in chain
    logic       st_ld;
    logic [1:0] st_code;
    logic       out_ld;
  } chi_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic kind_rm;
    logic head_is_idx;
    logic walk_stop;
    logic link_is_idx;
    logic out_free;
  } chi_sts_t;

endpackage

FILE: rtl/chi_ram.sv
`timescale 1ns / 1ps
module chi_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/chi_ctrl.sv
`timescale 1ns / 1ps
module chi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  chi_pkg::chi_sts_t sts,
  output chi_pkg::chi_cmd_t cmd
);
  import chi_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_Q    = 4'd2;
  localparam logic [3:0] S_R    = 4'd3;
  localparam logic [3:0] S_HRD  = 4'd4;
  localparam logic [3:0] S_HCHK = 4'd5;
  localparam logic [3:0] S_WCHK = 4'd6;
  localparam logic [3:0] S_WDAT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.acc = 1'b1;
          if (sts.in_range) begin
            state_nxt = S_Q;
          end else begin
            cmd.st_ld   = 1'b1;
            cmd.st_code = ST_RANGE;
            state_nxt   = S_DONE;
          end
        end
      end
      S_Q: begin
        cmd.q_ld  = 1'b1;
        state_nxt = S_R;
      end
      S_R: begin
        cmd.b_ld  = 1'b1;
        state_nxt = S_HRD;
      end
      S_HRD: begin
        state_nxt = S_HCHK;
      end
      S_HCHK: begin
        if (!sts.kind_rm) begin
          cmd.add_wr  = 1'b1;
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_DONE;
          state_nxt   = S_DONE;
        end else if (sts.head_is_idx) begin
          cmd.rmh_wr  = 1'b1;
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_DONE;
          state_nxt   = S_DONE;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WCHK;
        end
      end
      S_WCHK: begin
        cmd.link_at_cur = 1'b1;
        if (sts.walk_stop) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_MISS;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_WDAT;
        end
      end
      S_WDAT: begin
        cmd.link_at_cur = 1'b1;
        if (sts.link_is_idx) begin
          cmd.rml_wr  = 1'b1;
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_DONE;
          state_nxt   = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_WCHK;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_out_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("result loaded while output register still occupied");

  a_range_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !sts.in_range) |=> (state_r == S_DONE))
    else $error("out-of-range transaction did not go straight to result");

endmodule

FILE: rtl/chi_dp.sv
`timescale 1ns / 1ps
module chi_dp #(
  parameter int BUCKETS = 1024,
  parameter int INDICES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [chi_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_tuser,
  input  logic [chi_pkg::IN_DW-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [chi_pkg::OUT_DW-1:0] out_tdata,
  input  chi_pkg::chi_cmd_t          cmd,
  output chi_pkg::chi_sts_t          sts
);
  import chi_pkg::*;

  localparam int BAW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IAW   = (INDICES > 1) ? $clog2(INDICES) : 1;
  localparam int LW    = $clog2(INDICES) + 1;  // all ones marks end of chain
  localparam int LIMW  = ($clog2(INDICES + 1) > 13) ? $clog2(INDICES + 1) : 13;
  localparam int RECIP = 65536 / BUCKETS;      // floor(2^16 / BUCKETS)
  localparam logic [LW-1:0] EMPTY = '1;

  // Config
  logic [3:0]        bucket_bits_r;
  logic [CFG_DW-1:0] index_limit_r;

  // Per-transaction state
  logic              kind_r;
  logic [MASK_W-1:0] key_r;
  logic [IDX_W-1:0]  idx_r;
  logic [LIMW-1:0]   limit_r;
  logic [MASK_W-1:0] q_r;
  logic [BAW-1:0]    b_r;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     nidx_r;
  logic [LIMW-1:0]   steps_r, steps_nxt;
  logic [1:0]        st_r;
  logic [BAW-1:0]    clr_r;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [1:0]        out_st_r;

  logic [IDX_W-1:0]  in_idx;
  logic [LIMW-1:0]   live_lim;
  logic [MASK_W-1:0] mask, vkey;
  logic [31:0]       qprod, qb, rem, rem_fix;

  logic              head_we, link_we;
  logic [BAW-1:0]    head_waddr;
  logic [LW-1:0]     head_wdata, head_q;
  logic [IAW-1:0]    link_waddr, link_raddr;
  logic [LW-1:0]     link_wdata, link_q;

  assign in_idx   = in_tdata[KEY_W +: IDX_W];
  assign live_lim = (LIMW'(index_limit_r) < LIMW'(INDICES)) ?
                    LIMW'(index_limit_r) : LIMW'(INDICES);

  // Bucket = (key & mask) mod BUCKETS, reciprocal estimate then one fix-up
  assign mask    = ~({MASK_W{1'b1}} << bucket_bits_r);
  assign vkey    = key_r & mask;
  assign qprod   = 32'(vkey) * 32'(RECIP);
  assign qb      = 32'(q_r) * 32'(BUCKETS);
  assign rem     = 32'(vkey) - qb;
  assign rem_fix = (rem >= 32'(BUCKETS)) ? (rem - 32'(BUCKETS)) : rem;

  // Head memory: sweep, push, or unlink-at-head
  always_comb begin
    head_we    = cmd.clr_wr | cmd.add_wr | cmd.rmh_wr;
    head_waddr = cmd.clr_wr ? clr_r : b_r;
    priority if (cmd.clr_wr) begin
      head_wdata = EMPTY;
    end else if (cmd.add_wr) begin
      head_wdata = LW'(idx_r);
    end else begin
      head_wdata = link_q;
    end
  end

  // Link memory: push writes old head, bypass writes unlinked index's next
  always_comb begin
    link_we    = cmd.add_wr | cmd.rml_wr;
    link_waddr = cmd.add_wr ? IAW'(idx_r) : IAW'(cur_r);
    link_wdata = cmd.add_wr ? head_q : nidx_r;
    link_raddr = cmd.link_at_cur ? IAW'(cur_r) : IAW'(idx_r);
  end

  chi_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (b_r),
    .rdata (head_q)
  );

  chi_ram #(.WIDTH(LW), .DEPTH(INDICES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_q)
  );

  // Walk pointer and step count
  always_comb begin
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    if (cmd.walk_init) begin
      cur_nxt   = head_q;
      steps_nxt = '0;
    end else if (cmd.walk_step) begin
      cur_nxt   = link_q;
      steps_nxt = steps_r + LIMW'(1);
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_ld) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_bits_r <= BUCKET_BITS_RST;
      index_limit_r <= INDEX_LIMIT_RST;
      clr_r         <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BUCKET_BITS: bucket_bits_r <= cfg_wdata[3:0];
          CFG_INDEX_LIMIT: index_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr_wr) clr_r <= clr_r + BAW'(1);
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      kind_r  <= in_tuser;
      key_r   <= in_tdata[MASK_W-1:0];
      idx_r   <= in_idx;
      limit_r <= live_lim;
    end
    if (cmd.q_ld)      q_r    <= qprod[MASK_W+15:16];
    if (cmd.b_ld)      b_r    <= BAW'(rem_fix);
    if (cmd.walk_init) nidx_r <= link_q;
    if (cmd.st_ld)     st_r   <= cmd.st_code;
    if (cmd.out_ld)    out_st_r <= st_r;
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DW-2){1'b0}}, out_st_r};

  always_comb begin
    sts.clr_last    = (clr_r == BAW'(BUCKETS - 1));
    sts.in_range    = (LIMW'(in_idx) < live_lim);
    sts.kind_rm     = (kind_r == KIND_REMOVE);
    sts.head_is_idx = (32'(head_q) == 32'(idx_r));
    sts.walk_stop   = (steps_r >= limit_r) || (cur_r == EMPTY) ||
                      (32'(cur_r) >= 32'(INDICES));
    sts.link_is_idx = (32'(link_q) == 32'(idx_r));
    sts.out_free    = !out_tvalid_r || out_tready;
  end

  a_head_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.add_wr, cmd.rmh_wr}))
    else $error("conflicting head memory writes");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> (steps_r < limit_r))
    else $error("chain walk ran past index limit");

  a_add_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add_wr || cmd.rmh_wr) |-> (LIMW'(idx_r) < limit_r))
    else $error("table update for out-of-range index");

endmodule

FILE: rtl/chained_hash_index_table.sv
`timescale 1ns / 1ps
// Chained hash index table: one head word per bucket, one next link per index.
// Input stream (in_*): one transaction per add or remove request. tuser = kind
// (0 add, 1 remove); tdata = hash_key[31:0], entry_index[43:32], zero pad.
// Output stream (out_*): one status per request: 0 done, 1 index at or above
// the index limit (table untouched), 2 remove did not find the index.
// Config port: cfg_we/cfg_index/cfg_wdata, 0 = bucket_bits, 1 = index_limit;
// write only while no request is outstanding.
// One request is processed at a time by a small sequencer over two RAMs
// (bucket heads, next links), each with one write port and a registered read.
// From accept to status loaded in the output register: an out-of-range request
//   goes straight to the result; adds and head removals pass the quotient,
//   bucket, head read and head check states; other removes then walk the chain
//   (one RAM read plus compare per link) and end in one more check when no link
//   matches; the walk is bounded by the live index limit. The sequencer then
//   returns to idle with in_tready high. After reset the head RAM is swept to all
// ones with in_tready low; config writes are taken during the sweep.
// A finished status sits in the output register; the next request is accepted
// while it waits. If out_tready stays low, the following request stalls in its
// final cycle until the register frees up.
module chained_hash_index_table #(
  parameter int BUCKETS = 1024,
  parameter int INDICES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // config
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [chi_pkg::CFG_DW-1:0] cfg_wdata,
  // request stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_tuser,   // [0] kind
  input  logic [chi_pkg::IN_DW-1:0]  in_tdata,   // [31:0] hash_key, [43:32] entry_index
  // status stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [chi_pkg::OUT_DW-1:0] out_tdata   // [1:0] status
);
  import chi_pkg::*;

  chi_cmd_t cmd;
  chi_sts_t sts;

  // Sequencer: clear sweep, bucket compute, head check, chain walk, result
  chi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Config, bucket reduction, memories, walk registers, output register
  chi_dp #(
    .BUCKETS (BUCKETS),
    .INDICES (INDICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
